// ===== rtl/qpc_pkg.sv =====
`default_nettype none

package qpc_pkg;

    localparam int ROW_W   = 8;
    localparam int COUNT_W = 7;

    localparam logic [COUNT_W-1:0] TALLY_MAX = 7'd127;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_EMIT
    } qpc_state_t;

    typedef struct packed {
        logic load;
        logic active;
    } cell_ctrl_t;

    typedef struct packed {
        logic has_cand;
    } cell_stat_t;

endpackage

`default_nettype wire

// ===== rtl/qpc_cell.sv =====
`default_nettype none

module qpc_cell
    import qpc_pkg::*;
#(
    parameter int N = 8
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [ROW_W-1:0] row_in,
    input  wire logic [N-1:0]     cols_in,
    input  wire logic [N-1:0]     dl_in,
    input  wire logic [N-1:0]     dr_in,
    output cell_stat_t            stat,
    output logic [N-1:0]          cols_out,
    output logic [N-1:0]          dl_out,
    output logic [N-1:0]          dr_out
);

    logic [N-1:0]       blk_reg;
    logic [N-1:0]       q_reg;
    logic [N-1:0]       q_next;
    logic [N-1:0]       cols_reg;
    logic [N-1:0]       dl_reg;
    logic [N-1:0]       dr_reg;
    logic [N+ROW_W-1:0] row_ext;
    logic [N-1:0]       free_sq;
    logic [N-1:0]       tried;
    logic [N-1:0]       cand;
    logic [N-1:0]       pick;

    assign row_ext = {{N{1'b0}}, row_in};
    assign free_sq = ~(cols_in | dl_in | dr_in | blk_reg);
    assign tried   = (q_reg == '0) ? '0 : ((q_reg << 1) - {{(N-1){1'b0}}, 1'b1});
    assign cand    = free_sq & ~tried;
    assign pick    = cand & (~cand + {{(N-1){1'b0}}, 1'b1});

    assign stat.has_cand = |cand;
    assign cols_out      = cols_reg;
    assign dl_out        = dl_reg;
    assign dr_out        = dr_reg;

    always_comb
    begin
        q_next = q_reg;
        if (ctrl.active)
        begin
            q_next = pick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            blk_reg <= row_ext[N-1:0];
        end
        if (ctrl.active && stat.has_cand)
        begin
            cols_reg <= cols_in | pick;
            dl_reg   <= (dl_in | pick) << 1;
            dr_reg   <= (dr_in | pick) >> 1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/queen_placement_counter_core.sv =====
`default_nettype none

// Counts the queen placements on a BOARD_SIZE board with blocked squares.
// Send one transaction per row, top row first; bit j of blocked_row blocks
// column j. Rows load at one per cycle. The transaction carrying the last
// row starts a backtracking search over a row of cells, one cell per board
// row. The search sequencer takes one step per cycle, either placing a queen
// or abandoning a row, so the search time of a board grows with the number
// of nodes in its search tree, and a crowded board has far fewer of them.
// The row input stays stalled while the search runs and while
// a finished count waits for the output register to free up. The count is
// held in an output register and the next board may load while it waits.
// Counts saturate at 127.
module queen_placement_counter_core
    import qpc_pkg::*;
#(
    parameter int BOARD_SIZE = 8
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [ROW_W-1:0]   blocked_row,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [COUNT_W-1:0]      placement_count
);

    localparam int LW = $clog2(BOARD_SIZE);
    localparam logic [LW-1:0] LAST = LW'(BOARD_SIZE - 1);

    qpc_state_t         state_reg, state_next;
    logic [LW-1:0]      rows_reg, rows_next;
    logic [LW-1:0]      level_reg, level_next;
    logic [COUNT_W-1:0] tally_reg, tally_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    cell_ctrl_t         ctrl [BOARD_SIZE];
    cell_stat_t         stat [BOARD_SIZE];
    logic [BOARD_SIZE-1:0] has_vec;
    logic [BOARD_SIZE-1:0] cols_w [BOARD_SIZE+1];
    logic [BOARD_SIZE-1:0] dl_w   [BOARD_SIZE+1];
    logic [BOARD_SIZE-1:0] dr_w   [BOARD_SIZE+1];

    logic in_acc;
    logic has_cand;

    assign in_ready        = (state_reg == ST_LOAD);
    assign in_acc          = in_valid && in_ready;
    assign out_valid       = out_valid_reg;
    assign placement_count = count_reg;
    assign has_cand        = has_vec[level_reg];

    assign cols_w[0] = '0;
    assign dl_w[0]   = '0;
    assign dr_w[0]   = '0;

    for (genvar i = 0; i < BOARD_SIZE; i++)
    begin : g_cell
        assign ctrl[i].load   = in_acc && (rows_reg == LW'(i));
        assign ctrl[i].active = (state_reg == ST_SEARCH) && (level_reg == LW'(i));
        assign has_vec[i]     = stat[i].has_cand;

        qpc_cell #(
            .N (BOARD_SIZE)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl[i]),
            .row_in   (blocked_row),
            .cols_in  (cols_w[i]),
            .dl_in    (dl_w[i]),
            .dr_in    (dr_w[i]),
            .stat     (stat[i]),
            .cols_out (cols_w[i+1]),
            .dl_out   (dl_w[i+1]),
            .dr_out   (dr_w[i+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        level_next     = level_reg;
        tally_next     = tally_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (rows_reg == LAST)
                    begin
                        rows_next  = '0;
                        level_next = '0;
                        tally_next = '0;
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        rows_next = rows_reg + LW'(1);
                    end
                end
            end
            ST_SEARCH:
            begin
                if (has_cand)
                begin
                    if (level_reg == LAST)
                    begin
                        if (tally_reg != TALLY_MAX)
                        begin
                            tally_next = tally_reg + COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        level_next = level_reg + LW'(1);
                    end
                end
                else if (level_reg != '0)
                begin
                    level_next = level_reg - LW'(1);
                end
                else if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    count_next     = tally_reg;
                    state_next     = ST_LOAD;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    count_next     = tally_reg;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            rows_reg      <= '0;
            level_reg     <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            level_reg     <= level_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
    end

endmodule

`default_nettype wire
